>>> hw/rtl/rhht_pkg.sv
// Package for the Robin Hood hash table: word types, slot entry layout,
// codes and state encoding. Depends on nothing.
`default_nettype none
package rhht_pkg;

    localparam int SLOTS_DEF  = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int DIST_BITS  = 8;
    localparam int LIMIT_BITS = 8;
    localparam int LIVE_BITS  = 9;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd192;

    localparam logic [1:0] KIND_GET     = 2'd0;
    localparam logic [1:0] KIND_SET     = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_UPDATED   = 3'd1;
    localparam logic [2:0] STAT_FOUND     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_REMOVED   = 3'd4;
    localparam logic [2:0] STAT_REFUSED   = 3'd5;

    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_LIVE = 2'd1;
    localparam logic [1:0] SLOT_TOMB = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]            status;
        logic [VALUE_BITS-1:0] read_value;
        logic [LIVE_BITS-1:0]  live_count;
    } t_out_word;

    typedef struct packed {
        logic [1:0]            status;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [DIST_BITS-1:0]  probe_len;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/rhht_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module rhht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/rhht_ctrl.sv
// Probe sequencer: hashes the key, walks the slot memory one slot per
// read/evaluate pair and keeps the used and tombstone counts. Uses rhht_pkg.
`default_nettype none
module rhht_ctrl #(
    parameter int SLOTS = rhht_pkg::SLOTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire rhht_pkg::t_in_word               i_in,
    input  wire logic [rhht_pkg::LIMIT_BITS-1:0]  i_limit,
    output logic                                  o_ready,
    output logic                                  o_res_valid,
    output rhht_pkg::t_out_word                   o_res,
    input  wire logic                             i_res_take,
    output logic                                  o_ram_we,
    output logic [$clog2(SLOTS)-1:0]              o_ram_addr,
    output rhht_pkg::t_entry                      o_ram_wdata,
    input  wire rhht_pkg::t_entry                 i_ram_rdata
);

    localparam int  IW   = $clog2(SLOTS);
    localparam int  CW   = $clog2(SLOTS + 1);
    localparam int  DW   = $clog2(SLOTS + 256) + 1;
    localparam int  LW   = (CW > rhht_pkg::LIMIT_BITS) ? CW : rhht_pkg::LIMIT_BITS;
    localparam int  HW   = $clog2(rhht_pkg::KEY_BITS);
    localparam bit  POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    rhht_pkg::t_state                  r_state, n_state;
    logic [IW-1:0]                     r_idx, n_idx;
    logic [CW-1:0]                     r_used, n_used;
    logic [CW-1:0]                     r_tomb, n_tomb;
    logic [CW-1:0]                     r_steps, n_steps;
    logic [DW-1:0]                     r_dist, n_dist;
    logic [HW-1:0]                     r_cnt, n_cnt;
    logic [1:0]                        r_kind, n_kind;
    logic [rhht_pkg::KEY_BITS-1:0]     r_key, n_key;
    logic [rhht_pkg::VALUE_BITS-1:0]   r_val, n_val;
    logic                              r_swapped, n_swapped;
    logic [2:0]                        r_status, n_status;
    logic [rhht_pkg::VALUE_BITS-1:0]   r_rdval, n_rdval;

    logic [IW-1:0]                     idx_next;
    logic [IW:0]                       hash_t;
    logic [rhht_pkg::DIST_BITS-1:0]    dist_sat;
    logic                              refuse;
    logic [31:0]                       live32;

    assign idx_next = (r_idx == LAST) ? '0 : r_idx + 1'b1;
    assign hash_t   = {r_idx, r_key[~r_cnt]};
    assign dist_sat = (r_dist > DW'(255)) ? 8'd255 : r_dist[rhht_pkg::DIST_BITS-1:0];
    assign refuse   = (LW'(r_used) >= LW'(i_limit)) || (r_used >= CW'(SLOTS));
    assign live32   = 32'(r_used) - 32'(r_tomb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rhht_pkg::ST_CLEAR;
            r_idx   <= '0;
            r_used  <= '0;
            r_tomb  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_used  <= n_used;
            r_tomb  <= n_tomb;
        end
        r_steps   <= n_steps;
        r_dist    <= n_dist;
        r_cnt     <= n_cnt;
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_val     <= n_val;
        r_swapped <= n_swapped;
        r_status  <= n_status;
        r_rdval   <= n_rdval;
    end

    // Next state and the registers that follow it.
    always_comb begin
        rhht_pkg::t_entry d;
        d         = i_ram_rdata;
        n_state   = r_state;
        n_idx     = r_idx;
        n_used    = r_used;
        n_tomb    = r_tomb;
        n_steps   = r_steps;
        n_dist    = r_dist;
        n_cnt     = r_cnt;
        n_kind    = r_kind;
        n_key     = r_key;
        n_val     = r_val;
        n_swapped = r_swapped;
        n_status  = r_status;
        n_rdval   = r_rdval;
        case (r_state)
            rhht_pkg::ST_CLEAR: begin
                n_idx = idx_next;
                if (r_idx == LAST) begin
                    n_state = rhht_pkg::ST_IDLE;
                end
            end
            rhht_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_kind    = i_in.kind;
                    n_key     = i_in.key;
                    n_val     = i_in.value;
                    n_idx     = '0;
                    n_cnt     = '0;
                    n_steps   = '0;
                    n_dist    = '0;
                    n_swapped = 1'b0;
                    n_rdval   = '0;
                    n_status  = rhht_pkg::STAT_NOT_FOUND;
                    n_state   = rhht_pkg::ST_HASH;
                    if (i_in.kind == rhht_pkg::KIND_SET && refuse) begin
                        n_status = rhht_pkg::STAT_REFUSED;
                        n_state  = rhht_pkg::ST_DONE;
                    end else if (i_in.kind == rhht_pkg::KIND_REMOVE && r_used == '0) begin
                        n_state = rhht_pkg::ST_DONE;
                    end else if (i_in.kind != rhht_pkg::KIND_GET &&
                                 i_in.kind != rhht_pkg::KIND_SET &&
                                 i_in.kind != rhht_pkg::KIND_REMOVE) begin
                        n_state = rhht_pkg::ST_DONE;
                    end
                end
            end
            rhht_pkg::ST_HASH: begin
                if (POW2) begin
                    n_idx   = r_key[IW-1:0];
                    n_state = rhht_pkg::ST_READ;
                end else begin
                    // One key bit per cycle, most significant first.
                    if (hash_t >= (IW+1)'(SLOTS)) begin
                        n_idx = IW'(hash_t - (IW+1)'(SLOTS));
                    end else begin
                        n_idx = IW'(hash_t);
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == HW'(rhht_pkg::KEY_BITS - 1)) begin
                        n_state = rhht_pkg::ST_READ;
                    end
                end
            end
            rhht_pkg::ST_READ: begin
                if (r_steps == CW'(SLOTS)) begin
                    n_status = (r_kind == rhht_pkg::KIND_SET) ?
                               rhht_pkg::STAT_REFUSED : rhht_pkg::STAT_NOT_FOUND;
                    n_state  = rhht_pkg::ST_DONE;
                end else begin
                    n_state = rhht_pkg::ST_EVAL;
                end
            end
            rhht_pkg::ST_EVAL: begin
                n_state = rhht_pkg::ST_READ;
                n_idx   = idx_next;
                n_steps = r_steps + 1'b1;
                n_dist  = r_dist + 1'b1;
                if (r_kind == rhht_pkg::KIND_SET) begin
                    if (d.status != rhht_pkg::SLOT_LIVE) begin
                        n_idx    = r_idx;
                        n_status = rhht_pkg::STAT_INSERTED;
                        n_state  = rhht_pkg::ST_DONE;
                        if (d.status == rhht_pkg::SLOT_FREE) begin
                            n_used = r_used + 1'b1;
                        end else if (r_tomb != '0) begin
                            n_tomb = r_tomb - 1'b1;
                        end
                    end else if (d.key == r_key) begin
                        n_idx    = r_idx;
                        n_status = r_swapped ? rhht_pkg::STAT_INSERTED
                                             : rhht_pkg::STAT_UPDATED;
                        n_state  = rhht_pkg::ST_DONE;
                    end else if (DW'(d.probe_len) < r_dist) begin
                        // Evict the richer resident and carry it onward.
                        n_key     = d.key;
                        n_val     = d.value;
                        n_dist    = DW'(d.probe_len) + 1'b1;
                        n_swapped = 1'b1;
                    end
                end else begin
                    if (d.status == rhht_pkg::SLOT_LIVE && d.key == r_key) begin
                        n_idx   = r_idx;
                        n_state = rhht_pkg::ST_DONE;
                        if (r_kind == rhht_pkg::KIND_REMOVE) begin
                            n_tomb   = r_tomb + 1'b1;
                            n_status = rhht_pkg::STAT_REMOVED;
                        end else begin
                            n_status = rhht_pkg::STAT_FOUND;
                            n_rdval  = d.value;
                        end
                    end else if (d.status == rhht_pkg::SLOT_FREE) begin
                        n_idx   = r_idx;
                        n_state = rhht_pkg::ST_DONE;
                    end
                end
            end
            rhht_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = rhht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rhht_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        rhht_pkg::t_entry d;
        d                 = i_ram_rdata;
        o_ram_we          = 1'b0;
        o_ram_addr        = r_idx;
        o_ram_wdata       = d;
        o_ready           = (r_state == rhht_pkg::ST_IDLE);
        o_res_valid       = (r_state == rhht_pkg::ST_DONE);
        o_res.status      = r_status;
        o_res.read_value  = r_rdval;
        o_res.live_count  = live32[rhht_pkg::LIVE_BITS-1:0];
        case (r_state)
            rhht_pkg::ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = '0;
            end
            rhht_pkg::ST_EVAL: begin
                if (r_kind == rhht_pkg::KIND_SET) begin
                    if (d.status != rhht_pkg::SLOT_LIVE ||
                        (d.key != r_key && DW'(d.probe_len) < r_dist)) begin
                        o_ram_we = 1'b1;
                        o_ram_wdata.status    = rhht_pkg::SLOT_LIVE;
                        o_ram_wdata.key       = r_key;
                        o_ram_wdata.value     = r_val;
                        o_ram_wdata.probe_len = dist_sat;
                    end else if (d.key == r_key) begin
                        o_ram_we = 1'b1;
                        o_ram_wdata.value     = r_val;
                        o_ram_wdata.probe_len = dist_sat;
                    end
                end else if (r_kind == rhht_pkg::KIND_REMOVE &&
                             d.status == rhht_pkg::SLOT_LIVE && d.key == r_key) begin
                    o_ram_we = 1'b1;
                    o_ram_wdata.status = rhht_pkg::SLOT_TOMB;
                    o_ram_wdata.value  = '0;
                end
            end
            default: begin
                o_ram_we = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    a_tomb_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tomb <= r_used) else $error("tombstone count above used count");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(SLOTS)) else $error("used count above slot count");
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rhht_pkg::ST_CLEAR |-> !o_ready) else $error("ready during clear");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rhht_pkg::ST_EVAL && r_kind == rhht_pkg::KIND_SET &&
        i_ram_rdata.status == rhht_pkg::SLOT_FREE |=> r_used == $past(r_used) + 1'b1)
        else $error("insert into free slot did not count");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/robin_hood_hash_table_unit.sv
// Top level of the Robin Hood hash table: slot memory, probe sequencer,
// load limit register and result register. Uses rhht_pkg, rhht_ram, rhht_ctrl.
//
// Usage: one input word is a get, set or remove on a key; each gives one
// result word with a status, the value read by a get and the live count.
// Both channels are valid/ready; the result sits in an output register, so
// a new word is taken while a result still waits for the receiver.
// Steps: a hash step (worked through the key bit by bit when SLOTS is not a
// power of two), then a memory read and an evaluate-and-write-back on the
// single memory port for each probed slot, then a hand-off to the result
// register. Refused sets, removes on an empty table and unknown kinds skip
// the hash and probe steps and go straight to the hand-off.
// One word is in work at a time. At reset a clearing pass writes every
// slot free with input ready held low; the load limit returns to 192 and
// may be written at any idle time. When the receiver stalls, a finished
// word waits in the sequencer until the register frees.
`default_nettype none
module robin_hood_hash_table_unit #(
    parameter int SLOTS = rhht_pkg::SLOTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rhht_pkg::t_in_word              i_in_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output rhht_pkg::t_out_word                  o_out_word,
    input  wire logic                            i_cfg_we,
    input  wire logic [rhht_pkg::LIMIT_BITS-1:0] i_cfg_wdata
);

    logic [rhht_pkg::LIMIT_BITS-1:0] r_limit;
    logic                            r_out_valid;
    rhht_pkg::t_out_word             r_out_word;
    logic                            res_valid;
    logic                            res_take;
    rhht_pkg::t_out_word             res;
    logic                            ram_we;
    logic [$clog2(SLOTS)-1:0]        ram_addr;
    rhht_pkg::t_entry                ram_wdata;
    rhht_pkg::t_entry                ram_rdata;

    assign res_take    = res_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= rhht_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_take) begin
            r_out_word <= res;
        end
    end

    rhht_ram #(
        .WIDTH ($bits(rhht_pkg::t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    rhht_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && o_in_ready),
        .i_in        (i_in_word),
        .i_limit     (r_limit),
        .o_ready     (o_in_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for robin_hood_hash_table_unit: directed and random get/set/remove
// words checked against an in-bench hash table predictor. Uses rhht_pkg.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = rhht_pkg::SLOTS_DEF;
    localparam int KB = rhht_pkg::KEY_BITS;
    localparam int VB = rhht_pkg::VALUE_BITS;
    localparam int LIVE_W = rhht_pkg::LIVE_BITS;
    localparam int WATCHDOG = 20000;

    class hash_scoreboard;
        logic [1:0]            tab_state [NSLOT];
        logic [KB-1:0]         tab_key   [NSLOT];
        logic [VB-1:0]         tab_val   [NSLOT];
        int unsigned           tab_dist  [NSLOT];
        int unsigned           n_used;
        int unsigned           n_tomb;
        int unsigned           limit;
        rhht_pkg::t_out_word   pending [$];
        int unsigned           n_err;
        int unsigned           n_checked;
        int unsigned           stat_seen [8];

        function new();
            for (int i = 0; i < NSLOT; i++) tab_state[i] = rhht_pkg::SLOT_FREE;
            n_used = 0;
            n_tomb = 0;
            limit = rhht_pkg::LIMIT_RESET;
            n_err = 0;
            n_checked = 0;
            foreach (stat_seen[i]) stat_seen[i] = 0;
        endfunction

        function int locate(logic [KB-1:0] k);
            int idx;
            idx = k % NSLOT;
            for (int n = 0; n < NSLOT; n++) begin
                if (tab_state[idx] == rhht_pkg::SLOT_LIVE && tab_key[idx] == k) return idx;
                if (tab_state[idx] == rhht_pkg::SLOT_FREE) break;
                idx = (idx + 1) % NSLOT;
            end
            return -1;
        endfunction

        function logic [2:0] insert(logic [KB-1:0] k, logic [VB-1:0] v);
            int unsigned idx;
            int unsigned d;
            int unsigned td;
            bit moved;
            logic [KB-1:0] tk;
            logic [VB-1:0] tv;
            d = 0;
            moved = 0;
            if (n_used >= limit || n_used >= NSLOT) return rhht_pkg::STAT_REFUSED;
            idx = k % NSLOT;
            for (int n = 0; n < NSLOT; n++) begin
                if (tab_state[idx] != rhht_pkg::SLOT_LIVE) begin
                    if (tab_state[idx] == rhht_pkg::SLOT_FREE) n_used++;
                    else if (n_tomb > 0) n_tomb--;
                    tab_state[idx] = rhht_pkg::SLOT_LIVE;
                    tab_key[idx] = k;
                    tab_val[idx] = v;
                    tab_dist[idx] = (d > 255) ? 255 : d;
                    return rhht_pkg::STAT_INSERTED;
                end
                if (tab_key[idx] == k) begin
                    tab_val[idx] = v;
                    tab_dist[idx] = (d > 255) ? 255 : d;
                    return moved ? rhht_pkg::STAT_INSERTED : rhht_pkg::STAT_UPDATED;
                end
                if (tab_dist[idx] < d) begin
                    tk = tab_key[idx];
                    tv = tab_val[idx];
                    td = tab_dist[idx];
                    tab_key[idx] = k;
                    tab_val[idx] = v;
                    tab_dist[idx] = (d > 255) ? 255 : d;
                    k = tk;
                    v = tv;
                    d = td;
                    moved = 1;
                end
                idx = (idx + 1) % NSLOT;
                d++;
            end
            return rhht_pkg::STAT_REFUSED;
        endfunction

        function void note_input(rhht_pkg::t_in_word w);
            rhht_pkg::t_out_word r;
            int idx;
            r.status = rhht_pkg::STAT_NOT_FOUND;
            r.read_value = '0;
            if (w.kind == rhht_pkg::KIND_GET) begin
                idx = locate(w.key);
                if (idx >= 0) begin
                    r.status = rhht_pkg::STAT_FOUND;
                    r.read_value = tab_val[idx];
                end
            end else if (w.kind == rhht_pkg::KIND_SET) begin
                r.status = insert(w.key, w.value);
            end else if (w.kind == rhht_pkg::KIND_REMOVE && n_used != 0) begin
                idx = locate(w.key);
                if (idx >= 0) begin
                    tab_state[idx] = rhht_pkg::SLOT_TOMB;
                    tab_val[idx] = '0;
                    n_tomb++;
                    r.status = rhht_pkg::STAT_REMOVED;
                end
            end
            r.live_count = LIVE_W'(n_used - n_tomb);
            pending.push_back(r);
        endfunction

        function void check_result(rhht_pkg::t_out_word got);
            rhht_pkg::t_out_word exp;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                n_err++;
                return;
            end
            exp = pending.pop_front();
            n_checked++;
            stat_seen[exp.status]++;
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                n_err++;
            end
            if (got.read_value !== exp.read_value) begin
                $error("read_value: expected %h, actual %h", exp.read_value, got.read_value);
                n_err++;
            end
            if (got.live_count !== exp.live_count) begin
                $error("live_count: expected %0d, actual %0d", exp.live_count, got.live_count);
                n_err++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    rhht_pkg::t_in_word  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    rhht_pkg::t_out_word o_out_word;
    logic                i_cfg_we = 1'b0;
    logic [rhht_pkg::LIMIT_BITS-1:0] i_cfg_wdata = '0;

    hash_scoreboard table_sb = new();
    int unsigned idle_cycles = 0;
    bit          hold_recv = 1'b0;
    bit          stim_done = 1'b0;
    logic [KB-1:0] key_pool [16];

    always #6 i_clk = ~i_clk;

    robin_hood_hash_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Results are checked and accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) table_sb.check_result(o_out_word);
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : receiver
        int unsigned g;
        @(posedge i_clk);
        forever begin
            if (hold_recv) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Valid stays high after an accept unless a gap follows, so each edge
    // sees at most one update of the input signals.
    task automatic send_word(input logic [1:0] kind, input logic [KB-1:0] key,
                             input logic [VB-1:0] value);
        int unsigned g;
        rhht_pkg::t_in_word w;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        w.kind = kind;
        w.key = key;
        w.value = value;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        table_sb.note_input(w);
    endtask

    task automatic wait_drained();
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [rhht_pkg::LIMIT_BITS-1:0] lim);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_sb.limit = lim;
    endtask

    // Keys come mostly from a pool of 16 keys or from home slots 0 to 7, so probe runs, swaps and
    // tombstone reuse happen often.
    function automatic logic [KB-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return key_pool[$urandom_range(0, 15)];
        if (r < 9) return {24'($urandom()), 8'($urandom_range(0, 7))};
        return $urandom();
    endfunction

    task automatic random_phase(input int n, input int set_pct, input int rem_pct);
        int unsigned r;
        logic [1:0] k;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < set_pct) k = rhht_pkg::KIND_SET;
            else if (r < set_pct + rem_pct) k = rhht_pkg::KIND_REMOVE;
            else if (r < 97) k = rhht_pkg::KIND_GET;
            else k = rhht_pkg::KIND_UNKNOWN;
            send_word(k, pick_key(), $urandom());
        end
    endtask

    initial begin : main
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty remove, extremes of fields, updates, unknown kind,
        // wrap from the last slot, tombstone reuse and swaps on one home slot.
        send_word(rhht_pkg::KIND_REMOVE, 32'h0, 32'h0);
        send_word(rhht_pkg::KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(rhht_pkg::KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(rhht_pkg::KIND_SET, 32'h0000_00FF, 32'h0000_0000);
        send_word(rhht_pkg::KIND_SET, 32'h0000_0000, 32'hA5A5_5A5A);
        send_word(rhht_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0);
        send_word(rhht_pkg::KIND_SET, 32'hFFFF_FFFF, 32'h1234_5678);
        send_word(rhht_pkg::KIND_GET, 32'h0000_00FF, 32'h0);
        send_word(rhht_pkg::KIND_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(rhht_pkg::KIND_REMOVE, 32'h0000_00FF, 32'h0);
        send_word(rhht_pkg::KIND_REMOVE, 32'h0000_00FF, 32'h0);
        send_word(rhht_pkg::KIND_GET, 32'h0000_00FF, 32'h0);
        send_word(rhht_pkg::KIND_SET, 32'h0000_01FF, 32'h5555_AAAA);
        send_word(rhht_pkg::KIND_SET, 32'h0000_0100, 32'h1);
        send_word(rhht_pkg::KIND_SET, 32'h0000_0001, 32'h2);
        send_word(rhht_pkg::KIND_SET, 32'h0000_0200, 32'h3);
        send_word(rhht_pkg::KIND_SET, 32'h0000_0001, 32'h4);
        send_word(rhht_pkg::KIND_GET, 32'h0000_0200, 32'h0);
        send_word(rhht_pkg::KIND_GET, 32'h0000_0002, 32'h0);

        // Limit of one: every set is refused once something is stored.
        write_limit(8'd1);
        send_word(rhht_pkg::KIND_SET, 32'h0000_0000, 32'h9);
        send_word(rhht_pkg::KIND_SET, 32'h0000_0077, 32'h9);
        random_phase(60, 50, 20);

        write_limit(8'd255);
        random_phase(350, 70, 5);
        hold_recv = 1'b1;
        random_phase(300, 40, 30);

        write_limit(8'd20);
        random_phase(250, 45, 35);

        write_limit(8'($urandom_range(2, 254)));
        random_phase(500, 45, 35);
        stim_done = 1'b1;
        i_in_valid <= 1'b0;
        wait_drained();
        $display("tb: %0d results checked: %0d inserted, %0d updated, %0d found, %0d missed,",
                 table_sb.n_checked, table_sb.stat_seen[rhht_pkg::STAT_INSERTED],
                 table_sb.stat_seen[rhht_pkg::STAT_UPDATED],
                 table_sb.stat_seen[rhht_pkg::STAT_FOUND],
                 table_sb.stat_seen[rhht_pkg::STAT_NOT_FOUND]);
        $display("tb: %0d removed, %0d refused, limits 1, 255, 20 and a random one",
                 table_sb.stat_seen[rhht_pkg::STAT_REMOVED],
                 table_sb.stat_seen[rhht_pkg::STAT_REFUSED]);
        if (table_sb.n_err == 0 && table_sb.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG);
        $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
